// File: rtl/core/vlsu_pkg.sv
// Shared types and constants for the vector load/store unit.
// No dependencies; used by vlsu_agen, vlsu_extract and vector_load_store_unit.
`default_nettype none

package vlsu_pkg;

  localparam int unsigned NUM_VREGS  = 32;
  localparam int unsigned VREG_IDX_W = 5;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned ROW_W      = 4 * WORD_W;

  typedef enum logic [3:0] {
    KIND_VLD      = 4'd0,
    KIND_VST      = 4'd1,
    KIND_VLDREP_B = 4'd2,
    KIND_VLDREP_H = 4'd3,
    KIND_VLDREP_W = 4'd4,
    KIND_VLDREP_D = 4'd5,
    KIND_VSTELM_B = 4'd6,
    KIND_VSTELM_H = 4'd7,
    KIND_VSTELM_W = 4'd8,
    KIND_VSTELM_D = 4'd9,
    KIND_VLDX     = 4'd10,
    KIND_VSTX     = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    SM_NONE,
    SM_FULL,
    SM_ELEM
  } store_mode_t;

  // log2 of element size in bytes
  localparam logic [1:0] LG_B = 2'd0;
  localparam logic [1:0] LG_H = 2'd1;
  localparam logic [1:0] LG_W = 2'd2;
  localparam logic [1:0] LG_D = 2'd3;

  localparam logic [5:0] BYTES_FULL = 6'd32;

  typedef struct packed {
    logic [63:0] addr;
    logic        is_store;
    logic [5:0]  access_bytes;
    store_mode_t mode;
    logic [1:0]  lg;
    logic [1:0]  word_sel;
    logic [5:0]  lane_shift;
  } lsu_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/vlsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vlsu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // holds its data when not enabled
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vlsu_agen.sv
// Decode and address generation: kind and instruction fields to address,
// size, store control and register file write data. Uses vlsu_pkg.
`default_nettype none

module vlsu_agen (
  input  wire logic [3:0]               kind,
  input  wire logic [31:0]              instr_word,
  input  wire logic [63:0]              base_value,
  input  wire logic [63:0]              index_value,
  input  wire logic [63:0]              load_word0,
  input  wire logic [63:0]              load_word1,
  input  wire logic [63:0]              load_word2,
  input  wire logic [63:0]              load_word3,
  output vlsu_pkg::lsu_ctl_t            ctl,
  output logic                          wr_en,
  output logic [vlsu_pkg::ROW_W-1:0]    wr_data
);

  logic [11:0] f;
  logic [4:0]  idx;
  logic [63:0] off12;
  logic [63:0] off_rep;
  logic [63:0] off_elm;
  logic [63:0] rep_word;
  logic [1:0]  lg;

  assign f   = instr_word[21:10];
  assign idx = instr_word[22:18];
  assign lg  = kind[1:0] + 2'd2;  // kind 2..5 -> 0..3, kind 6..9 -> 0..3

  assign off12 = {{52{f[11]}}, f[11:0]};

  always_comb begin
    case (lg)
      vlsu_pkg::LG_B: off_rep = off12;
      vlsu_pkg::LG_H: off_rep = {{52{f[10]}}, f[10:0], 1'b0};
      vlsu_pkg::LG_W: off_rep = {{52{f[9]}}, f[9:0], 2'b0};
      default:        off_rep = {{52{f[8]}}, f[8:0], 3'b0};
    endcase
    off_elm = {{56{f[7]}}, f[7:0]} << lg;
    case (lg)
      vlsu_pkg::LG_B: rep_word = {8{load_word0[7:0]}};
      vlsu_pkg::LG_H: rep_word = {4{load_word0[15:0]}};
      vlsu_pkg::LG_W: rep_word = {2{load_word0[31:0]}};
      default:        rep_word = load_word0;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mode     = vlsu_pkg::SM_NONE;
    ctl.lg       = lg;
    wr_en        = 1'b0;
    wr_data      = {load_word3, load_word2, load_word1, load_word0};
    unique case (kind) inside
      vlsu_pkg::KIND_VLD: begin
        ctl.addr         = base_value + off12;
        ctl.access_bytes = vlsu_pkg::BYTES_FULL;
        wr_en            = 1'b1;
      end
      vlsu_pkg::KIND_VLDX: begin
        ctl.addr         = base_value + index_value;
        ctl.access_bytes = vlsu_pkg::BYTES_FULL;
        wr_en            = 1'b1;
      end
      vlsu_pkg::KIND_VST: begin
        ctl.addr         = base_value + off12;
        ctl.access_bytes = vlsu_pkg::BYTES_FULL;
        ctl.is_store     = 1'b1;
        ctl.mode         = vlsu_pkg::SM_FULL;
      end
      vlsu_pkg::KIND_VSTX: begin
        ctl.addr         = base_value + index_value;
        ctl.access_bytes = vlsu_pkg::BYTES_FULL;
        ctl.is_store     = 1'b1;
        ctl.mode         = vlsu_pkg::SM_FULL;
      end
      vlsu_pkg::KIND_VLDREP_B, vlsu_pkg::KIND_VLDREP_H,
      vlsu_pkg::KIND_VLDREP_W, vlsu_pkg::KIND_VLDREP_D: begin
        ctl.addr         = base_value + off_rep;
        ctl.access_bytes = 6'd1 << lg;
        wr_en            = 1'b1;
        wr_data          = {4{rep_word}};
      end
      vlsu_pkg::KIND_VSTELM_B, vlsu_pkg::KIND_VSTELM_H,
      vlsu_pkg::KIND_VSTELM_W, vlsu_pkg::KIND_VSTELM_D: begin
        ctl.addr         = base_value + off_elm;
        ctl.access_bytes = 6'd1 << lg;
        ctl.is_store     = 1'b1;
        ctl.mode         = vlsu_pkg::SM_ELEM;
        // word = idx / lanes-per-word, shift = lane * element bits
        case (lg)
          vlsu_pkg::LG_B: begin
            ctl.word_sel   = idx[4:3];
            ctl.lane_shift = {idx[2:0], 3'b0};
          end
          vlsu_pkg::LG_H: begin
            ctl.word_sel   = idx[3:2];
            ctl.lane_shift = {idx[1:0], 4'b0};
          end
          vlsu_pkg::LG_W: begin
            ctl.word_sel   = idx[2:1];
            ctl.lane_shift = {idx[0], 5'b0};
          end
          default: begin
            ctl.word_sel   = idx[1:0];
            ctl.lane_shift = 6'd0;
          end
        endcase
      end
      default: begin
        // unused kinds: no access, no write, all-zero result
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/vlsu_extract.sv
// Store data path: picks the full row or one element from the register file
// read data. Uses vlsu_pkg.
`default_nettype none

module vlsu_extract (
  input  wire logic [vlsu_pkg::ROW_W-1:0] row,
  input  wire logic                       row_valid,
  input  wire vlsu_pkg::lsu_ctl_t         ctl,
  output logic [63:0]                     store_word0,
  output logic [63:0]                     store_word1,
  output logic [63:0]                     store_word2,
  output logic [63:0]                     store_word3
);

  logic [vlsu_pkg::ROW_W-1:0] data;
  logic [63:0]                word;
  logic [63:0]                val;

  // a row never written reads as zero
  assign data = row_valid ? row : '0;

  always_comb begin
    word = data[ctl.word_sel*64 +: 64];
    val  = word >> ctl.lane_shift;
    case (ctl.lg)
      vlsu_pkg::LG_B: val = {56'd0, val[7:0]};
      vlsu_pkg::LG_H: val = {48'd0, val[15:0]};
      vlsu_pkg::LG_W: val = {32'd0, val[31:0]};
      default:        val = val;
    endcase

    store_word0 = '0;
    store_word1 = '0;
    store_word2 = '0;
    store_word3 = '0;
    case (ctl.mode)
      vlsu_pkg::SM_FULL: begin
        store_word0 = data[63:0];
        store_word1 = data[127:64];
        store_word2 = data[191:128];
        store_word3 = data[255:192];
      end
      vlsu_pkg::SM_ELEM: store_word0 = val;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/vector_load_store_unit.sv
// Vector load/store unit top level: register file RAM, valid bits, pipeline.
// Depends on vlsu_pkg, vlsu_ram, vlsu_agen, vlsu_extract.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  request | req_valid / req_ready | kind, instr_word, base/index, load_word0..3
//  result  | rsp_valid / rsp_ready | mem_address, is_store, access_bytes,
//          |                       | store_word0..3
//
// One item per cycle sustained while results are taken; each request passes
// through the register file RAM read, then the output register, to the result.
// Loads write the 32 x 256-bit register file RAM at the request transfer;
// stores read it at the same edge, so program order needs no forwarding.
// Reset clears 32 row valid bits; an unwritten row reads as zero.
// A stalled result holds the read stage, which stops new request transfers.
`default_nettype none

module vector_load_store_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [3:0]  kind,
  input  wire logic [31:0] instr_word,
  input  wire logic [63:0] base_value,
  input  wire logic [63:0] index_value,
  input  wire logic [63:0] load_word0,
  input  wire logic [63:0] load_word1,
  input  wire logic [63:0] load_word2,
  input  wire logic [63:0] load_word3,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [63:0]      mem_address,
  output logic             is_store,
  output logic [5:0]       access_bytes,
  output logic [63:0]      store_word0,
  output logic [63:0]      store_word1,
  output logic [63:0]      store_word2,
  output logic [63:0]      store_word3
);

  vlsu_pkg::lsu_ctl_t                  ctl;
  logic                                wr_en;
  logic [vlsu_pkg::ROW_W-1:0]          wr_data;
  logic [vlsu_pkg::VREG_IDX_W-1:0]     xd;
  logic                                accept;
  logic                                adv;
  logic                                rd_en;
  logic [vlsu_pkg::ROW_W-1:0]          rd_data;
  logic [vlsu_pkg::NUM_VREGS-1:0]      row_valid;
  logic [vlsu_pkg::NUM_VREGS-1:0]      row_valid_next;
  logic                                s1_valid;
  vlsu_pkg::lsu_ctl_t                  s1_ctl;
  logic                                s1_row_valid;
  logic [63:0]                         sw0, sw1, sw2, sw3;

  assign xd        = instr_word[vlsu_pkg::VREG_IDX_W-1:0];
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || adv;
  assign accept    = req_valid && req_ready;
  assign rd_en     = accept;

  vlsu_agen u_agen (
    .kind        (kind),
    .instr_word  (instr_word),
    .base_value  (base_value),
    .index_value (index_value),
    .load_word0  (load_word0),
    .load_word1  (load_word1),
    .load_word2  (load_word2),
    .load_word3  (load_word3),
    .ctl         (ctl),
    .wr_en       (wr_en),
    .wr_data     (wr_data)
  );

  vlsu_ram #(
    .WIDTH (vlsu_pkg::ROW_W),
    .DEPTH (vlsu_pkg::NUM_VREGS)
  ) u_vregs (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (xd),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (xd),
    .rd_data (rd_data)
  );

  always_comb begin
    row_valid_next = row_valid;
    if (accept && wr_en) begin
      row_valid_next[xd] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      row_valid <= row_valid_next;
      if (req_ready) begin
        s1_valid <= accept;
      end
      if (adv) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl       <= ctl;
      s1_row_valid <= row_valid[xd];
    end
  end

  vlsu_extract u_extract (
    .row         (rd_data),
    .row_valid   (s1_row_valid),
    .ctl         (s1_ctl),
    .store_word0 (sw0),
    .store_word1 (sw1),
    .store_word2 (sw2),
    .store_word3 (sw3)
  );

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      mem_address  <= s1_ctl.addr;
      is_store     <= s1_ctl.is_store;
      access_bytes <= s1_ctl.access_bytes;
      store_word0  <= sw0;
      store_word1  <= sw1;
      store_word2  <= sw2;
      store_word3  <= sw3;
    end
  end

  // a stalled read stage must keep its RAM read data
  a_no_read_in_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |-> !rd_en)
    else $error("register file read issued while read stage stalled");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_ctl))
    else $error("read stage lost its item during a stall");

  a_load_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_store |->
      store_word0 == 64'd0 && store_word1 == 64'd0 &&
      store_word2 == 64'd0 && store_word3 == 64'd0)
    else $error("store data present on a load result");

  a_bytes_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (access_bytes == 6'd0 || access_bytes == 6'd1 ||
                   access_bytes == 6'd2 || access_bytes == 6'd4 ||
                   access_bytes == 6'd8 || access_bytes == 6'd32))
    else $error("illegal access size on result");

endmodule

`default_nettype wire
